// ===== design/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and codes of the marquee scroll position core: register
// indexes, scroll and alignment codes, and the pipeline payload structures.
// ----------------------------------------------------------------------------
package msp_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_SCROLL_MODE  = 3'd0;
	localparam logic [2:0] REG_START_MARGIN = 3'd1;
	localparam logic [2:0] REG_END_MARGIN   = 3'd2;
	localparam logic [2:0] REG_INTERVAL_MS  = 3'd3;
	localparam logic [2:0] REG_PAUSE_MS     = 3'd4;
	localparam logic [2:0] REG_LOOP_ENABLE  = 3'd5;
	localparam logic [2:0] REG_LOOP_GAP     = 3'd6;
	localparam logic [2:0] REG_FIT_ALIGN    = 3'd7;

	// Scroll modes
	localparam logic [1:0] MODE_HORIZ = 2'd0;
	localparam logic [1:0] MODE_HREV  = 2'd1;
	localparam logic [1:0] MODE_VUP   = 2'd2;
	localparam logic [1:0] MODE_VREV  = 2'd3;

	// Alignment of text that fits the box
	localparam logic [1:0] FIT_LEFT   = 2'd0;
	localparam logic [1:0] FIT_CENTRE = 2'd1;
	localparam logic [1:0] FIT_RIGHT  = 2'd2;

	localparam int IN_BYTES_W  = 152;
	localparam int OUT_BYTES_W = 160;

	// Result of one transaction
	typedef struct packed {
		logic [31:0] cnt;
		logic [15:0] cpy;
		logic [15:0] cpx;
		logic [15:0] csy;
		logic [15:0] csx;
		logic [15:0] y2;
		logic [15:0] x2;
		logic [15:0] y1;
		logic [15:0] x1;
	} res_t;

	// Payload travelling down the pipeline
	typedef struct packed {
		logic [31:0]        elapsed;
		logic [15:0]        ox;
		logic [15:0]        oy;
		logic [14:0]        w;
		logic [14:0]        h;
		logic [14:0]        tw;
		logic [14:0]        th;
		logic [9:0]         lc;
		logic [7:0]         lh;
		logic [7:0]         ls;
		logic [17:0]        rem;
		logic [15:0]        phase;
		logic signed [20:0] ext;
		logic               scr;
		logic               fit;
		logic [15:0]        off;
		logic [15:0]        p1;
		logic [15:0]        p2;
		logic [15:0]        cp;
		logic [15:0]        c1;
		logic [15:0]        c2;
		logic [19:0]        trav;
		logic [35:0]        num;
		logic [19:0]        quo;
		logic [15:0]        drem;
		res_t               res;
	} pl_t;

endpackage

// ===== design/marquee_scroll_position_core.sv =====
// ----------------------------------------------------------------------------
// marquee_scroll_position_core
// Pipelined scroll position of a marquee text box, one frame request per
// transaction.
// ----------------------------------------------------------------------------
// Each input transaction yields one result after 17 pipeline stages and a new
// transaction may enter every cycle unless stalled. Eight stages take the
// elapsed time modulo the pass length (interval plus pause) four bits a
// stage, one stage forms the phase and the text extent, one selects the
// travel distance and the coordinate offsets, one multiplies distance by
// phase, five divide the product by the interval four quotient bits a stage,
// and the last stage forms the rectangle into the output register.
// Stages advance independently, so bubbles close up while the output waits.
// Configuration must be written only while the pipeline is empty; unchecked.
module marquee_scroll_position_core #(
	parameter int COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// elapsed_ms, origin_x, origin_y, box_width, box_height, text_width,
	// text_height, line_count, line_height, line_spacing, 2 zero bits
	input  logic [msp_pkg::IN_BYTES_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// rect_x1, rect_y1, rect_x2, rect_y2, char_shift_x, char_shift_y,
	// copy_shift_x, copy_shift_y, scroll_count
	output logic [msp_pkg::OUT_BYTES_W-1:0] m_tdata
);
	import msp_pkg::*;

	localparam int NS    = 17;
	localparam int S_PH  = 9;
	localparam int S_SEL = 10;
	localparam int S_MUL = 11;
	localparam int S_DIV = 12;
	localparam int CSH   = 16 - COORD_BITS;

	// Wrap a coordinate to COORD_BITS and sign-extend to 16 bits
	function automatic logic [15:0] crd(input logic [15:0] v);
		logic signed [15:0] t;
		t = $signed(v << CSH);
		return 16'(t >>> CSH);
	endfunction

	// Configuration registers
	logic [1:0]  mode_q;
	logic [15:0] start_q;
	logic [15:0] end_q;
	logic [15:0] interval_q;
	logic [15:0] pause_q;
	logic        loop_q;
	logic [15:0] gap_q;
	logic [1:0]  fit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_HORIZ;
			start_q    <= '0;
			end_q      <= '0;
			interval_q <= 16'd1;
			pause_q    <= '0;
			loop_q     <= 1'b0;
			gap_q      <= '0;
			fit_q      <= FIT_CENTRE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCROLL_MODE:  mode_q     <= cfg_data[1:0];
				REG_START_MARGIN: start_q    <= cfg_data;
				REG_END_MARGIN:   end_q      <= cfg_data;
				REG_INTERVAL_MS:  interval_q <= cfg_data;
				REG_PAUSE_MS:     pause_q    <= cfg_data;
				REG_LOOP_ENABLE:  loop_q     <= cfg_data[0];
				REG_LOOP_GAP:     gap_q      <= cfg_data;
				REG_FIT_ALIGN:    fit_q      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Interval with zero treated as one, and the full pass length
	logic [15:0] iv;
	logic [17:0] pass_len;
	assign iv       = (interval_q == '0) ? 16'd1 : interval_q;
	assign pass_len = 18'(iv) + 18'(pause_q);

	// Pipeline storage and handshake
	pl_t        in_item;
	pl_t        stg [0:NS-1];
	pl_t        nx [1:NS];
	pl_t        pl_s [1:NS];
	logic [NS:1] vld_s;
	logic [NS:1] adv;
	logic [NS:1] vin;

	always_comb begin
		in_item         = '0;
		in_item.elapsed = s_tdata[31:0];
		in_item.ox      = s_tdata[47:32];
		in_item.oy      = s_tdata[63:48];
		in_item.w       = s_tdata[78:64];
		in_item.h       = s_tdata[93:79];
		in_item.tw      = s_tdata[108:94];
		in_item.th      = s_tdata[123:109];
		in_item.lc      = s_tdata[133:124];
		in_item.lh      = s_tdata[141:134];
		in_item.ls      = s_tdata[149:142];
	end

	assign stg[0] = in_item;
	for (genvar k = 1; k <= NS - 1; k++) begin : g_view
		assign stg[k] = pl_s[k];
	end

	// Stage advances when empty or when the next one advances
	always_comb begin
		adv[NS] = !vld_s[NS] || m_tready;
		for (int k = NS - 1; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end
	assign vin      = {vld_s[NS-1:1], s_tvalid};
	assign s_tready = adv[1];
	assign m_tvalid = vld_s[NS];
	assign m_tdata  = pl_s[NS].res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (adv[k]) vld_s[k] <= vin[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NS; k++) begin
			if (adv[k]) pl_s[k] <= nx[k];
		end
	end

	// Elapsed time modulo pass length, four bits per stage
	for (genvar g = 0; g < 8; g++) begin : g_mod
		logic [17:0] r;
		always_comb begin
			nx[g+1] = stg[g];
			r = stg[g].rem;
			for (int i = 0; i < 4; i++) begin
				r = {r[16:0], stg[g].elapsed[31-4*g-i]};
				if (r >= pass_len) r = r - pass_len;
			end
			nx[g+1].rem = r;
		end
	end

	// Phase (held at zero during the pause) and text extent
	logic [8:0]  ph_lsum;
	logic [18:0] ph_lprod;
	always_comb begin
		nx[S_PH] = stg[S_PH-1];
		nx[S_PH].phase = (stg[S_PH-1].rem < 18'(iv)) ? stg[S_PH-1].rem[15:0] : '0;
		ph_lsum  = 9'(stg[S_PH-1].lh) + 9'(stg[S_PH-1].ls);
		ph_lprod = 19'(stg[S_PH-1].lc) * 19'(ph_lsum);
		if (mode_q == MODE_VUP) begin
			nx[S_PH].ext = $signed(21'(ph_lprod) - 21'(stg[S_PH-1].ls));
		end else begin
			nx[S_PH].ext = $signed(21'(stg[S_PH-1].th));
		end
	end

	// Scroll decision, travel distance and coordinate offsets
	pl_t         sl;
	logic [15:0] sl_w;
	logic [15:0] sl_h;
	logic [15:0] sl_tw;
	logic [15:0] sl_e;
	logic [19:0] sl_e20;
	logic [14:0] sl_diff;
	logic [15:0] sl_base;
	logic [15:0] sl_total;
	logic [15:0] sl_d;
	always_comb begin
		sl       = stg[S_SEL-1];
		nx[S_SEL] = sl;
		sl_w     = 16'(sl.w);
		sl_h     = 16'(sl.h);
		sl_tw    = 16'(sl.tw);
		sl_e     = sl.ext[15:0];
		sl_e20   = sl.ext[19:0];
		sl_diff  = sl.w - sl.tw;
		sl_base  = loop_q ? '0 : start_q;
		sl_d     = (fit_q == FIT_CENTRE) ? 16'(sl_diff[14:1]) : 16'(sl_diff);
		sl_total = '0;
		if (!mode_q[1]) begin
			// Horizontal
			nx[S_SEL].scr = (sl.tw > sl.w);
			nx[S_SEL].fit = (sl.tw <= sl.w) && (fit_q == FIT_CENTRE || fit_q == FIT_RIGHT);
			sl_total = sl_tw + gap_q;
			if (sl.tw > sl.w) begin
				nx[S_SEL].off = (mode_q == MODE_HREV) ? sl_base + sl_tw - sl_w : sl_base;
			end else begin
				nx[S_SEL].off = sl_d;
			end
			nx[S_SEL].p1 = sl.ox;
			if (sl.tw > sl.w || nx[S_SEL].fit) begin
				nx[S_SEL].p2 = sl.ox + sl_tw - 16'd1;
			end else begin
				nx[S_SEL].p2 = sl.ox + sl_w - 16'd1;
			end
			if (sl.tw > sl.w && loop_q) begin
				nx[S_SEL].cp = (mode_q == MODE_HREV) ? 16'd0 - sl_total : sl_total;
			end else begin
				nx[S_SEL].cp = '0;
			end
			nx[S_SEL].c1 = sl.oy;
			nx[S_SEL].c2 = sl.oy + sl_h - 16'd1;
			nx[S_SEL].trav = loop_q ? 20'(sl.tw) + 20'(gap_q)
				: 20'(end_q) + 20'(start_q) + 20'(sl.tw) - 20'(sl.w);
		end else begin
			// Vertical
			nx[S_SEL].scr = (sl.ext > $signed({6'd0, sl.h})) || (sl.ext == '0);
			nx[S_SEL].fit = 1'b0;
			nx[S_SEL].off = sl_base;
			sl_total = sl_e + gap_q;
			if (!nx[S_SEL].scr) begin
				nx[S_SEL].p1 = sl.oy;
				nx[S_SEL].p2 = sl.oy + sl_h - 16'd1;
			end else if (mode_q == MODE_VUP) begin
				nx[S_SEL].p1 = sl.oy;
				nx[S_SEL].p2 = sl.oy + sl_e - 16'd1;
			end else begin
				nx[S_SEL].p1 = sl.oy + sl_h - sl_e - 16'd1;
				nx[S_SEL].p2 = sl.oy + sl_h;
			end
			if (nx[S_SEL].scr && loop_q) begin
				nx[S_SEL].cp = (mode_q == MODE_VUP) ? sl_total : 16'd0 - sl_total;
			end else begin
				nx[S_SEL].cp = '0;
			end
			nx[S_SEL].c1 = sl.ox;
			nx[S_SEL].c2 = sl.ox + sl_w - 16'd1;
			nx[S_SEL].trav = loop_q ? sl_e20 + 20'(gap_q)
				: 20'(end_q) + 20'(start_q) + sl_e20;
		end
	end

	// Distance times phase
	always_comb begin
		nx[S_MUL] = stg[S_MUL-1];
		nx[S_MUL].num = 36'(stg[S_MUL-1].trav) * 36'(stg[S_MUL-1].phase);
	end

	// Divide by the interval, four quotient bits per stage; the top part of
	// the product is already below the interval since phase is below it
	for (genvar g = 0; g < 5; g++) begin : g_div
		logic [15:0] r;
		logic [16:0] t;
		logic [19:0] q;
		always_comb begin
			nx[S_DIV+g] = stg[S_DIV+g-1];
			r = (g == 0) ? stg[S_DIV+g-1].num[35:20] : stg[S_DIV+g-1].drem;
			q = (g == 0) ? '0 : stg[S_DIV+g-1].quo;
			t = '0;
			for (int i = 0; i < 4; i++) begin
				t = {r, stg[S_DIV+g-1].num[19-4*g-i]};
				if (t >= {1'b0, iv}) begin
					r = 16'(t - {1'b0, iv});
					q = {q[18:0], 1'b1};
				end else begin
					r = t[15:0];
					q = {q[18:0], 1'b0};
				end
			end
			nx[S_DIV+g].drem = r;
			nx[S_DIV+g].quo  = q;
		end
	end

	// Shifts, rectangle and output mapping
	pl_t         fo;
	logic [15:0] fo_cnt;
	logic [15:0] fo_sh;
	logic [15:0] fo_t;
	logic [15:0] fo_cp;
	logic [15:0] fo_a1;
	logic [15:0] fo_a2;
	always_comb begin
		fo     = stg[NS-1];
		nx[NS] = fo;
		fo_cnt = fo.quo[15:0];
		if (fo.scr) begin
			case (mode_q)
				MODE_HREV: fo_sh = fo_cnt - fo.off;
				MODE_VREV: fo_sh = fo_cnt + 16'd1;
				default:   fo_sh = fo.off - fo_cnt;
			endcase
			fo_t  = (mode_q == MODE_VREV) ? fo_cnt : fo_sh;
			fo_cp = fo.cp;
			nx[NS].res.cnt = 32'(fo.quo);
		end else begin
			fo_sh = fo.fit ? fo.off : '0;
			fo_t  = fo_sh;
			fo_cp = '0;
			nx[NS].res.cnt = '0;
		end
		fo_a1 = fo.p1 + fo_t;
		fo_a2 = fo.p2 + fo_t;
		if (mode_q[1]) begin
			nx[NS].res.x1  = crd(fo.c1);
			nx[NS].res.x2  = crd(fo.c2);
			nx[NS].res.y1  = crd(fo_a1);
			nx[NS].res.y2  = crd(fo_a2);
			nx[NS].res.csx = '0;
			nx[NS].res.csy = crd(fo_sh);
			nx[NS].res.cpx = '0;
			nx[NS].res.cpy = crd(fo_cp);
		end else begin
			nx[NS].res.x1  = crd(fo_a1);
			nx[NS].res.x2  = crd(fo_a2);
			nx[NS].res.y1  = crd(fo.c1);
			nx[NS].res.y2  = crd(fo.c2);
			nx[NS].res.csx = crd(fo_sh);
			nx[NS].res.csy = '0;
			nx[NS].res.cpx = crd(fo_cp);
			nx[NS].res.cpy = '0;
		end
	end

endmodule
